// ----- src/assert_macros.svh -----
// Assertion macros for the RTL of the slab pool allocator.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Property checked on every rising clock edge outside reset.
`define SPA_ASSERT(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
    else $error("spa assertion failed");
// Property checked on every rising clock edge, reset included.
`define SPA_ASSERT_ALWAYS(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) prop) else $error("spa assertion failed");
`else
`define SPA_ASSERT(lbl, clk, rstn, prop)
`define SPA_ASSERT_ALWAYS(lbl, clk, prop)
`endif
`endif

// ----- src/spa_pkg.sv -----
// Constants and types of the slab pool allocator.
package spa_pkg;
  localparam int MAX_BLOCKS = 8;
  localparam int SLOTS      = 16;
  localparam int BLK_W      = $clog2(MAX_BLOCKS);
  localparam int SLOT_W     = $clog2(SLOTS);
  localparam int HANDLE_W   = BLK_W + SLOT_W;
  localparam int CNT_W      = $clog2(SLOTS + 1);
  localparam int LIST_W     = $clog2(MAX_BLOCKS + 1);
  localparam int TOTAL_W    = $clog2(MAX_BLOCKS * SLOTS + 1);
  localparam int STACK_DEPTH = MAX_BLOCKS * SLOTS;

  localparam logic KIND_ALLOC = 1'b0;
  localparam logic KIND_FREE  = 1'b1;

  localparam logic REG_SLOTS = 1'b0;
  localparam logic REG_KEEP  = 1'b1;

  typedef enum logic [1:0] {
    STATUS_OK        = 2'd0,
    STATUS_EXHAUSTED = 2'd1,
    STATUS_BAD_FREE  = 2'd2
  } status_e;
endpackage

// ----- src/spa_if.sv -----
// Valid/ready channel interfaces for requests and results.
interface spa_req_if;
  logic                         valid;
  logic                         ready;
  logic                         kind;
  logic [spa_pkg::HANDLE_W-1:0] free_handle;
  modport source (output valid, kind, free_handle, input ready);
  modport sink (input valid, kind, free_handle, output ready);
endinterface

interface spa_rsp_if;
  logic                         valid;
  logic                         ready;
  logic [1:0]                   status;
  logic [spa_pkg::HANDLE_W-1:0] handle;
  logic                         block_grown;
  logic                         block_released;
  logic [spa_pkg::TOTAL_W-1:0]  free_total;
  modport source (output valid, status, handle, block_grown, block_released, free_total,
                  input ready);
  modport sink (input valid, status, handle, block_grown, block_released, free_total,
                output ready);
endinterface

// ----- src/spa_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
module spa_ram #(
  parameter int Width = 8,
  parameter int Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;
endmodule

// ----- src/slab_pool_allocator_top.sv -----
// Top level of the slab pool allocator: control, block list and slot bookkeeping.
//
// The allocator serves one request at a time. A free passes through accept
// and update, its result registered in the update step; an allocate passes
// through accept, block choice and stack read, then slot commit, its result
// registered in the commit step, or at block choice if the pool is exhausted.
// The extra allocate step is set by the registered read data of the free-slot
// stack RAM, which holds a LIFO of returned slot numbers for each of the 8
// blocks of 16 slots. A new request is accepted while a finished result still
// waits in the output register; the block only pauses when it has a second
// result ready and the first is not yet taken. Per-block counters, the
// newest-first block list and the slot-allocated bits live in flip-flops
// cleared by reset, so no clearing pass is needed. Configuration (slots per
// block, blocks kept when empty) is written over the APB port at byte
// addresses 0 and 4 by the user, only while idle; the block does not enforce it.
`include "assert_macros.svh"

module slab_pool_allocator_top (
  input  logic         clk_i,
  input  logic         rst_ni,
  spa_req_if.sink      in_i,
  spa_rsp_if.source    out_o,
  input  logic         psel,
  input  logic         penable,
  input  logic         pwrite,
  input  logic [2:0]   paddr,
  input  logic [31:0]  pwdata,
  output logic [31:0]  prdata,
  output logic         pready
);
  localparam int NB = spa_pkg::MAX_BLOCKS;
  localparam int BW = spa_pkg::BLK_W;
  localparam int SW = spa_pkg::SLOT_W;
  localparam int HW = spa_pkg::HANDLE_W;
  localparam int CW = spa_pkg::CNT_W;
  localparam int LW = spa_pkg::LIST_W;
  localparam int TW = spa_pkg::TOTAL_W;

  typedef enum logic [1:0] {S_IDLE, S_EXEC, S_FIN} state_e;

  state_e state_q;

  logic [4:0]      slots_q;
  logic [3:0]      keep_q;

  logic [BW-1:0]   order_q [NB];
  logic [LW-1:0]   listed_q;
  logic [NB-1:0]   active_q;
  logic [CW-1:0]   used_q  [NB];
  logic [CW-1:0]   top_q   [NB];
  logic [CW-1:0]   fresh_q [NB];
  logic [spa_pkg::STACK_DEPTH-1:0] taken_q;
  logic [TW-1:0]   total_q;

  logic            kind_q;
  logic [HW-1:0]   req_handle_q;

  logic [BW-1:0]   sel_blk_q;
  logic            from_stack_q;
  logic [SW-1:0]   fresh_slot_q;
  logic            grown_q;

  logic            out_valid_q;
  logic [1:0]      out_status_q;
  logic [HW-1:0]   out_handle_q;
  logic            out_grown_q;
  logic            out_released_q;

  // Configuration port.
  logic cfg_we;
  assign cfg_we = psel & penable & pwrite;
  assign pready = 1'b1;
  always_comb begin
    prdata = '0;
    if (paddr[2] == spa_pkg::REG_SLOTS) prdata[4:0] = slots_q;
    else prdata[3:0] = keep_q;
  end

  // Effective slots per block, saturated to 1..SLOTS.
  logic [CW-1:0] eff_slots;
  always_comb begin
    if (slots_q == 5'd0) eff_slots = CW'(1);
    else if (CW'(slots_q) > CW'(spa_pkg::SLOTS)) eff_slots = CW'(spa_pkg::SLOTS);
    else eff_slots = CW'(slots_q);
  end

  logic out_busy;
  assign out_busy = out_valid_q & ~out_o.ready;
  assign in_i.ready = (state_q == S_IDLE);

  // Allocate decision: grow first when nothing is free, then the first
  // listed block with a free slot.
  logic          grow;
  logic          nb_found;
  logic [BW-1:0] nb;
  logic          can_grow;
  logic          scan_found;
  logic [BW-1:0] scan_blk;
  always_comb begin
    nb_found = 1'b0;
    nb = '0;
    for (int i = 0; i < NB; i++) begin
      if (!nb_found && !active_q[i]) begin
        nb_found = 1'b1;
        nb = BW'(i);
      end
    end
    scan_found = 1'b0;
    scan_blk = '0;
    for (int p = 0; p < NB; p++) begin
      if (!scan_found && (LW'(p) < listed_q) &&
          ((top_q[order_q[p]] != '0) || (fresh_q[order_q[p]] != '0))) begin
        scan_found = 1'b1;
        scan_blk = order_q[p];
      end
    end
  end
  assign grow     = (total_q == '0);
  assign can_grow = nb_found && (listed_q < LW'(NB));

  // Free decision.
  logic [BW-1:0] fb;
  logic          free_ok;
  logic          release_blk;
  logic [NB-1:0] rm_match;
  logic [NB-1:0] rm_after;
  assign fb = req_handle_q[HW-1:SW];
  assign free_ok = active_q[fb] && taken_q[req_handle_q] &&
                   (top_q[fb] < CW'(spa_pkg::SLOTS)) && (used_q[fb] != '0);
  assign release_blk = (used_q[fb] == CW'(1)) && ({1'b0, listed_q} > {1'b0, keep_q});
  always_comb begin
    for (int i = 0; i < NB; i++) begin
      rm_match[i] = (LW'(i) < listed_q) && (order_q[i] == fb);
    end
    rm_after[0] = rm_match[0];
    for (int i = 1; i < NB; i++) begin
      rm_after[i] = rm_after[i-1] | rm_match[i];
    end
  end

  // Freed-slot released-block arithmetic.
  logic [TW:0] rel_free;
  logic [TW:0] rel_total;
  assign rel_free  = (TW+1)'(top_q[fb]) + (TW+1)'(1) + (TW+1)'(fresh_q[fb]);
  assign rel_total = (TW+1)'(total_q) + (TW+1)'(1);

  // Stack RAM.
  logic          ram_we;
  logic [HW-1:0] ram_waddr;
  logic          ram_re;
  logic [HW-1:0] ram_raddr;
  logic [SW-1:0] ram_rdata;
  logic [CW-1:0] sel_top_dec;
  assign sel_top_dec = top_q[scan_blk] - CW'(1);
  assign ram_we    = (state_q == S_EXEC) && !out_busy && (kind_q == spa_pkg::KIND_FREE)
                     && free_ok;
  assign ram_waddr = {fb, top_q[fb][SW-1:0]};
  assign ram_re    = (state_q == S_EXEC) && (kind_q == spa_pkg::KIND_ALLOC) && !grow &&
                     scan_found && (top_q[scan_blk] != '0);
  assign ram_raddr = {scan_blk, sel_top_dec[SW-1:0]};

  spa_ram #(.Width(SW), .Depth(spa_pkg::STACK_DEPTH)) u_stack (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (req_handle_q[SW-1:0]),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  logic [SW-1:0] fin_slot;
  assign fin_slot = from_stack_q ? ram_rdata : fresh_slot_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q        <= S_IDLE;
      slots_q        <= 5'd16;
      keep_q         <= 4'd2;
      listed_q       <= '0;
      active_q       <= '0;
      taken_q        <= '0;
      total_q        <= '0;
      out_valid_q    <= 1'b0;
      out_status_q   <= spa_pkg::STATUS_OK;
      out_handle_q   <= '0;
      out_grown_q    <= 1'b0;
      out_released_q <= 1'b0;
      kind_q         <= spa_pkg::KIND_ALLOC;
      req_handle_q   <= '0;
      sel_blk_q      <= '0;
      from_stack_q   <= 1'b0;
      fresh_slot_q   <= '0;
      grown_q        <= 1'b0;
      for (int i = 0; i < NB; i++) begin
        order_q[i] <= '0;
        used_q[i]  <= '0;
        top_q[i]   <= '0;
        fresh_q[i] <= '0;
      end
    end else begin
      if (cfg_we) begin
        if (paddr[2] == spa_pkg::REG_SLOTS) slots_q <= pwdata[4:0];
        else keep_q <= pwdata[3:0];
      end
      if (out_valid_q && out_o.ready) out_valid_q <= 1'b0;

      case (state_q)
        S_IDLE: begin
          if (in_i.valid) begin
            kind_q       <= in_i.kind;
            req_handle_q <= in_i.free_handle;
            state_q      <= S_EXEC;
          end
        end
        S_EXEC: begin
          if (!out_busy) begin
            if (kind_q == spa_pkg::KIND_FREE) begin
              out_valid_q    <= 1'b1;
              out_handle_q   <= '0;
              out_grown_q    <= 1'b0;
              state_q        <= S_IDLE;
              if (!free_ok) begin
                out_status_q   <= spa_pkg::STATUS_BAD_FREE;
                out_released_q <= 1'b0;
              end else begin
                out_status_q            <= spa_pkg::STATUS_OK;
                taken_q[req_handle_q]   <= 1'b0;
                used_q[fb]              <= used_q[fb] - CW'(1);
                if (release_blk) begin
                  out_released_q <= 1'b1;
                  top_q[fb]      <= '0;
                  fresh_q[fb]    <= '0;
                  active_q[fb]   <= 1'b0;
                  total_q <= (rel_total >= rel_free) ? TW'(rel_total - rel_free) : '0;
                  for (int i = 0; i < NB - 1; i++) begin
                    if (rm_after[i]) order_q[i] <= order_q[i+1];
                  end
                  if (|rm_match) listed_q <= listed_q - LW'(1);
                end else begin
                  out_released_q <= 1'b0;
                  top_q[fb]      <= top_q[fb] + CW'(1);
                  total_q        <= total_q + TW'(1);
                end
              end
            end else if (grow) begin
              if (!can_grow) begin
                out_valid_q    <= 1'b1;
                out_status_q   <= spa_pkg::STATUS_EXHAUSTED;
                out_handle_q   <= '0;
                out_grown_q    <= 1'b0;
                out_released_q <= 1'b0;
                state_q        <= S_IDLE;
              end else begin
                // The new block goes to the head of the list and serves this
                // allocate from its highest fresh slot.
                order_q[0] <= nb;
                for (int i = 1; i < NB; i++) begin
                  order_q[i] <= order_q[i-1];
                end
                listed_q     <= listed_q + LW'(1);
                active_q[nb] <= 1'b1;
                used_q[nb]   <= CW'(1);
                top_q[nb]    <= '0;
                fresh_q[nb]  <= eff_slots - CW'(1);
                total_q      <= total_q + TW'(eff_slots) - TW'(1);
                sel_blk_q    <= nb;
                from_stack_q <= 1'b0;
                fresh_slot_q <= SW'(eff_slots - CW'(1));
                grown_q      <= 1'b1;
                state_q      <= S_FIN;
              end
            end else if (!scan_found) begin
              out_valid_q    <= 1'b1;
              out_status_q   <= spa_pkg::STATUS_EXHAUSTED;
              out_handle_q   <= '0;
              out_grown_q    <= 1'b0;
              out_released_q <= 1'b0;
              state_q        <= S_IDLE;
            end else begin
              sel_blk_q        <= scan_blk;
              grown_q          <= 1'b0;
              used_q[scan_blk] <= used_q[scan_blk] + CW'(1);
              total_q          <= total_q - TW'(1);
              if (top_q[scan_blk] != '0) begin
                top_q[scan_blk] <= sel_top_dec;
                from_stack_q    <= 1'b1;
              end else begin
                fresh_q[scan_blk] <= fresh_q[scan_blk] - CW'(1);
                fresh_slot_q      <= SW'(fresh_q[scan_blk] - CW'(1));
                from_stack_q      <= 1'b0;
              end
              state_q <= S_FIN;
            end
          end
        end
        S_FIN: begin
          if (!out_busy) begin
            taken_q[{sel_blk_q, fin_slot}] <= 1'b1;
            out_valid_q    <= 1'b1;
            out_status_q   <= spa_pkg::STATUS_OK;
            out_handle_q   <= {sel_blk_q, fin_slot};
            out_grown_q    <= grown_q;
            out_released_q <= 1'b0;
            state_q        <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign out_o.valid          = out_valid_q;
  assign out_o.status         = out_status_q;
  assign out_o.handle         = out_handle_q;
  assign out_o.block_grown    = out_grown_q;
  assign out_o.block_released = out_released_q;
  assign out_o.free_total     = total_q;

  `SPA_ASSERT(a_listed_matches_active, clk_i, rst_ni, $countones(active_q) == 32'(listed_q))
  `SPA_ASSERT(a_fin_follows_exec, clk_i, rst_ni,
    (state_q == S_FIN) |-> ($past(state_q) == S_EXEC || $past(state_q) == S_FIN))
  `SPA_ASSERT(a_fin_is_alloc, clk_i, rst_ni,
    (state_q == S_FIN) |-> (kind_q == spa_pkg::KIND_ALLOC))
  `SPA_ASSERT_ALWAYS(a_total_in_range, clk_i, total_q <= TW'(spa_pkg::STACK_DEPTH))
endmodule

// ----- dv/slab_pool_checker.sv -----
// Checker for the slab pool allocator: predicts every result and compares it.
`timescale 1ns / 1ps

module slab_pool_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  spa_req_if          req,
  spa_rsp_if          rsp,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  input  logic        pready,
  output int          err_count_o,
  output int          pending_o
);
  localparam int HW    = spa_pkg::HANDLE_W;
  localparam int TW    = spa_pkg::TOTAL_W;
  localparam int BW    = spa_pkg::BLK_W;
  localparam int SW    = spa_pkg::SLOT_W;
  localparam int NB    = spa_pkg::MAX_BLOCKS;
  localparam int NS    = spa_pkg::SLOTS;
  localparam int DEPTH = spa_pkg::STACK_DEPTH;

  typedef struct packed {
    spa_pkg::status_e  status;
    logic [HW-1:0]     handle;
    logic              grown;
    logic              released;
    logic [TW-1:0]     total;
  } pool_result_t;

  logic [4:0]         cfg_slots;
  logic [3:0]         cfg_keep;
  logic [BW-1:0]      pool_order [NB];
  int                 pool_len;
  logic               blk_live   [NB];
  int                 blk_used   [NB];
  logic [SW-1:0]      ret_stack  [NB][NS];
  int                 ret_top    [NB];
  int                 fresh_cnt  [NB];
  logic               taken      [DEPTH];
  int                 free_slots;
  pool_result_t       result_q[$];
  int                 mismatches;

  assign err_count_o = mismatches;
  assign pending_o   = result_q.size();

  function automatic pool_result_t predict_alloc();
    pool_result_t r;
    int nb, b, slot;
    r = '{spa_pkg::STATUS_EXHAUSTED, '0, 1'b0, 1'b0, '0};
    if (free_slots == 0) begin
      nb = NB;
      for (int i = NB - 1; i >= 0; i--) if (!blk_live[i]) nb = i;
      if (nb >= NB || pool_len >= NB) begin
        r.total = TW'(free_slots);
        return r;
      end
      for (int i = pool_len; i > 0; i--) pool_order[i] = pool_order[i-1];
      pool_order[0] = BW'(nb);
      pool_len++;
      blk_live[nb]  = 1'b1;
      blk_used[nb]  = 0;
      ret_top[nb]   = 0;
      fresh_cnt[nb] = (cfg_slots == 0) ? 1 : (cfg_slots > NS) ? NS : int'(cfg_slots);
      free_slots   += fresh_cnt[nb];
      r.grown = 1'b1;
    end
    for (int p = 0; p < pool_len; p++) begin
      b = pool_order[p];
      slot = -1;
      if (ret_top[b] > 0) begin
        ret_top[b]--;
        slot = ret_stack[b][ret_top[b]];
      end else if (fresh_cnt[b] > 0) begin
        fresh_cnt[b]--;
        slot = fresh_cnt[b];
      end
      if (slot >= 0) begin
        taken[b*NS + slot] = 1'b1;
        blk_used[b]++;
        if (free_slots > 0) free_slots--;
        r.status = spa_pkg::STATUS_OK;
        r.handle = HW'(b*NS + slot);
        r.total  = TW'(free_slots);
        return r;
      end
    end
    r.total = TW'(free_slots);
    return r;
  endfunction

  function automatic pool_result_t predict_free(logic [HW-1:0] h);
    pool_result_t r;
    int b, p, blk_free;
    b = int'(h) / NS;
    r = '{spa_pkg::STATUS_OK, '0, 1'b0, 1'b0, '0};
    if (!blk_live[b] || !taken[h] || ret_top[b] >= NS || blk_used[b] == 0) begin
      r.status = spa_pkg::STATUS_BAD_FREE;
      r.total  = TW'(free_slots);
      return r;
    end
    taken[h] = 1'b0;
    ret_stack[b][ret_top[b]] = SW'(int'(h) % NS);
    ret_top[b]++;
    blk_used[b]--;
    free_slots++;
    if (blk_used[b] == 0 && pool_len > cfg_keep) begin
      p = 0;
      while (p < pool_len && pool_order[p] != b) p++;
      if (p < pool_len) begin
        for (int i = p; i + 1 < pool_len; i++) pool_order[i] = pool_order[i+1];
        pool_len--;
      end
      blk_free   = ret_top[b] + fresh_cnt[b];
      free_slots = (free_slots >= blk_free) ? free_slots - blk_free : 0;
      ret_top[b] = 0;
      fresh_cnt[b] = 0;
      blk_live[b]  = 1'b0;
      r.released   = 1'b1;
    end
    r.total = TW'(free_slots);
    return r;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    pool_result_t want, got;
    if (!rst_ni) begin
      cfg_slots  <= 5'd16;
      cfg_keep   <= 4'd2;
      pool_len   = 0;
      free_slots = 0;
      mismatches <= 0;
      result_q.delete();
      for (int i = 0; i < NB; i++) begin
        blk_live[i] = 1'b0;
        blk_used[i] = 0;
        ret_top[i]  = 0;
        fresh_cnt[i] = 0;
      end
      for (int i = 0; i < DEPTH; i++) taken[i] = 1'b0;
    end else begin
      if (psel && penable && pwrite && pready) begin
        if (paddr[2] == spa_pkg::REG_SLOTS) cfg_slots <= pwdata[4:0];
        else cfg_keep <= pwdata[3:0];
      end
      // Results are checked before the new request is predicted; a request
      // accepted in this cycle cannot have produced its result yet.
      if (rsp.valid && rsp.ready) begin
        got = '{spa_pkg::status_e'(rsp.status), rsp.handle, rsp.block_grown,
                rsp.block_released, rsp.free_total};
        if (result_q.size() == 0) begin
          if (mismatches < 10) $display("%0t: result with none expected: %p", $realtime, got);
          mismatches <= mismatches + 1;
        end else begin
          want = result_q.pop_front();
          if (want != got) begin
            if (mismatches < 10)
              $display("%0t: result mismatch: expected %p, got %p", $realtime, want, got);
            mismatches <= mismatches + 1;
          end
        end
      end
      if (req.valid && req.ready) begin
        if (req.kind == spa_pkg::KIND_ALLOC) result_q.push_back(predict_alloc());
        else result_q.push_back(predict_free(req.free_handle));
      end
    end
  end
endmodule

// ----- dv/slab_pool_allocator_top_test.sv -----
// Testbench top for the slab pool allocator: stimulus, configuration and verdict.
`timescale 1ns / 1ps

module slab_pool_allocator_top_test;
  localparam int HW = spa_pkg::HANDLE_W;
  localparam int NS = spa_pkg::SLOTS;

  logic        clk_i;
  logic        rst_ni;
  logic        psel, penable, pwrite;
  logic [2:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;
  int          err_count, pending;

  // Percent chance per cycle that the sender or the receiver idles.
  int          tx_idle_pct, rx_idle_pct;
  // While set, the receiver refuses every result.
  logic        rx_hold;
  int          idle_cycles;

  // Handles that the block has handed out and that are not yet freed, and
  // the kinds of the requests whose results are still to come.
  logic [HW-1:0] live_handles[$];
  logic          kind_in_flight[$];

  spa_req_if req_if ();
  spa_rsp_if rsp_if ();

  slab_pool_allocator_top u_top (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .in_i    (req_if),
    .out_o   (rsp_if),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  slab_pool_checker u_checker (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req         (req_if),
    .rsp         (rsp_if),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .pready      (pready),
    .err_count_o (err_count),
    .pending_o   (pending)
  );

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  // The receiver decides its ready for the next cycle at every rising edge.
  always @(posedge clk_i) begin
    if (!rst_ni || rx_hold) begin
      rsp_if.ready <= 1'b0;
    end else begin
      rsp_if.ready <= ($urandom_range(99) >= rx_idle_pct);
    end
  end

  // Track which allocates succeeded so that most frees name a live slot.
  always @(posedge clk_i) begin
    logic k;
    if (rst_ni && rsp_if.valid && rsp_if.ready && kind_in_flight.size() > 0) begin
      k = kind_in_flight.pop_front();
      if (k == spa_pkg::KIND_ALLOC && rsp_if.status == spa_pkg::STATUS_OK)
        live_handles.push_back(rsp_if.handle);
    end
  end

  // The watchdog ends a run in which no transfer happens for too long.
  always @(posedge clk_i) begin
    if (!rst_ni || (req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles > 5000) begin
        $display("slab_pool_allocator_top_test: done, errors");
        $finish;
      end
    end
  end

  // Offer one request and hold it until it is taken. Ready is sampled in
  // the middle of the cycle, so the transfer happens at the following edge.
  task automatic send_request(logic kind, logic [HW-1:0] h);
    while ($urandom_range(99) < tx_idle_pct) begin
      req_if.valid <= 1'b0;
      @(posedge clk_i);
    end
    req_if.valid       <= 1'b1;
    req_if.kind        <= kind;
    req_if.free_handle <= h;
    kind_in_flight.push_back(kind);
    do @(negedge clk_i); while (!req_if.ready);
    @(posedge clk_i);
  endtask

  // Lower valid and wait until every expected result has been received.
  task automatic drain();
    req_if.valid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  // One register write: a setup phase and then an access phase.
  task automatic write_reg(logic idx, logic [31:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(negedge clk_i); while (!pready);
    @(posedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  // Random traffic: mostly allocates and frees of live slots, balanced
  // around a target fill level, with a share of frees at random handles.
  task automatic random_traffic(int count, int target);
    int idx;
    for (int n = 0; n < count; n++) begin
      if ($urandom_range(99) < 8) begin
        send_request(spa_pkg::KIND_FREE, HW'($urandom_range(127)));
      end else if (live_handles.size() == 0 ||
                   $urandom_range(99) < ((live_handles.size() < target) ? 65 : 30)) begin
        send_request(spa_pkg::KIND_ALLOC, HW'($urandom_range(127)));
      end else begin
        idx = $urandom_range(live_handles.size() - 1);
        send_request(spa_pkg::KIND_FREE, live_handles[idx]);
        live_handles.delete(idx);
      end
    end
  endtask

  // Slots per block and blocks kept, the register extremes among them.
  int phase_slots [8] = '{4, 1, 31, 0, 3, 16, 2, 7};
  int phase_keep  [8] = '{1, 0, 8, 15, 2, 0, 8, 3};

  initial begin
    rst_ni       = 1'b0;
    rx_hold      = 1'b0;
    tx_idle_pct  = 16;
    rx_idle_pct  = 87;
    psel         = 1'b0;
    penable      = 1'b0;
    pwrite       = 1'b0;
    paddr        = '0;
    pwdata       = '0;
    req_if.valid = 1'b0;
    req_if.kind  = spa_pkg::KIND_ALLOC;
    req_if.free_handle = '0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed part with the reset configuration: a first allocate grows a
    // block, then a good free, a double free, a free of an inactive block, a
    // second allocate and a free of a slot that was never handed out.
    send_request(spa_pkg::KIND_ALLOC, '0);
    send_request(spa_pkg::KIND_FREE, HW'(15));
    send_request(spa_pkg::KIND_FREE, HW'(15));
    send_request(spa_pkg::KIND_FREE, HW'(127));
    send_request(spa_pkg::KIND_ALLOC, '0);
    send_request(spa_pkg::KIND_FREE, HW'(0));
    drain();
    live_handles.delete();

    // Nothing kept: freeing the last slot in use releases the only block,
    // which leaves the pool empty.
    write_reg(spa_pkg::REG_KEEP, 32'd0);
    send_request(spa_pkg::KIND_FREE, HW'(15));
    drain();

    // One slot per block: eight allocates fill every block, the ninth finds
    // the pool exhausted, and each free releases its block.
    write_reg(spa_pkg::REG_SLOTS, 32'd1);
    for (int i = 0; i < 9; i++) send_request(spa_pkg::KIND_ALLOC, '0);
    for (int i = 7; i >= 0; i--) send_request(spa_pkg::KIND_FREE, HW'(i * NS));
    drain();
    live_handles.delete();

    for (int ph = 0; ph < 8; ph++) begin
      // Sender idles lightly at first, then the receiver, then neither.
      if (ph < 3) begin
        tx_idle_pct = 16;
        rx_idle_pct = 87;
      end else if (ph < 6) begin
        tx_idle_pct = 87;
        rx_idle_pct = 16;
      end else begin
        tx_idle_pct = 0;
        rx_idle_pct = 0;
      end
      write_reg(spa_pkg::REG_SLOTS, 32'(phase_slots[ph]));
      write_reg(spa_pkg::REG_KEEP, 32'(phase_keep[ph]));
      if (ph == 6) begin
        // The receiver stops for a long stretch while requests keep coming,
        // so the block fills its output and stops taking input.
        fork
          begin
            rx_hold <= 1'b1;
            repeat (300) @(posedge clk_i);
            rx_hold <= 1'b0;
          end
        join_none
      end
      random_traffic(135, (ph % 2 == 0) ? 40 : 12);
      drain();
    end

    repeat (20) @(posedge clk_i);
    if (err_count == 0) begin
      $display("slab_pool_allocator_top_test: done, clean");
    end else begin
      $display("slab_pool_allocator_top_test: done, errors");
    end
    $finish;
  end
endmodule
